@@ rtl/frame_queue_gop_discard_defines.svh @@
// Assertion macros used by the checker file of the frame queue.
`ifndef FRAME_QUEUE_GOP_DISCARD_DEFINES_SVH
`define FRAME_QUEUE_GOP_DISCARD_DEFINES_SVH

// Consequence must hold in the same cycle as the antecedent.
`define FQGD_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("frame queue assertion failed");

// Consequence must hold in the cycle after the antecedent.
`define FQGD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("frame queue assertion failed");

`endif

@@ rtl/fqgd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package fqgd_pkg;

    localparam int MIN_CAPACITY = 3;

    localparam logic [6:0] CAPACITY_RESET = 7'd64;
    localparam logic [6:0] WARN_RESET     = 7'd30;
    localparam logic [3:0] KEY_RESET      = 4'd1;

    localparam logic [1:0] REG_CAPACITY = 2'd0;
    localparam logic [1:0] REG_WARN     = 2'd1;
    localparam logic [1:0] REG_KEY      = 2'd2;
    localparam logic [1:0] REG_NOTIFY   = 2'd3;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_EMPTY  = 3'd1;
    localparam logic [2:0] ST_FULL   = 3'd2;
    localparam logic [2:0] ST_NOROOM = 3'd3;
    localparam logic [2:0] ST_SIZE0  = 3'd4;

    localparam logic [1:0] EV_NONE  = 2'd0;
    localparam logic [1:0] EV_ENTER = 2'd1;
    localparam logic [1:0] EV_CLEAR = 2'd2;

    typedef struct packed {
        logic [3:0]  ftype;
        logic [31:0] ts;
        logic [23:0] fsize;
        logic [31:0] pref;
    } t_entry;

    typedef struct packed {
        logic [6:0] capacity;
        logic [6:0] warn_level;
        logic [3:0] key_type;
        logic       notify;
    } t_cfg;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD_HEAD,
        S_RD_CHK,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_DROP,
        S_CP_RD,
        S_CP_WR,
        S_ROOM,
        S_WRITE
    } t_state;

endpackage
`default_nettype wire

@@ rtl/fqgd_mem.sv @@
`timescale 1ns / 1ps
`default_nettype none
module fqgd_mem #(
    parameter int DEPTH = 64
) (
    input  wire                       i_clk,
    input  wire                       i_we,
    input  wire                       i_re,
    input  wire  [$clog2(DEPTH)-1:0]  i_addr,
    input  fqgd_pkg::t_entry          i_wdata,
    output fqgd_pkg::t_entry          o_rdata
);
    import fqgd_pkg::*;

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    // Single address: the sequencer never reads and writes in the same cycle.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

@@ rtl/fqgd_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
module fqgd_ctrl #(
    parameter int DEPTH = 64
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  fqgd_pkg::t_cfg      i_cfg,
    input  wire                 i_start,
    input  wire                 i_command,
    input  fqgd_pkg::t_entry    i_item,
    input  wire                 i_blocking,
    output logic                o_busy,
    output logic                o_done,
    output logic                o_ok,
    output logic [2:0]          o_status,
    output fqgd_pkg::t_entry    o_item,
    output logic [1:0]          o_event,
    output logic [6:0]          o_occupancy,
    output logic [6:0]          o_dropped
);
    import fqgd_pkg::*;

    localparam int AW  = $clog2(DEPTH);
    localparam int CW  = $clog2(DEPTH + 1);
    localparam int SW  = CW + 1;
    localparam int CMP = (CW > 7) ? CW : 7;

    t_state        r_state, n_state;
    logic [AW-1:0] r_head, n_head;
    logic [CW-1:0] r_count, n_count;
    logic          r_cong, n_cong;
    logic [CW-1:0] r_idx, n_idx;
    logic [CW-1:0] r_p1, n_p1;
    logic [CW-1:0] r_p2, n_p2;
    logic          r_f1, n_f1;
    logic          r_f2, n_f2;
    logic [CW-1:0] r_src, n_src;
    logic [CW-1:0] r_dst, n_dst;
    t_entry        r_in, n_in;
    logic          r_done, n_done;
    logic          r_ok, n_ok;
    logic [2:0]    r_status, n_status;
    t_entry        r_out, n_out;
    logic [1:0]    r_event, n_event;
    logic [CW-1:0] r_dropped, n_dropped;

    logic [CMP-1:0] lim_wide;
    logic [CW-1:0]  lim;
    logic           full;
    logic           room_full;
    logic           hit;
    logic           accept;

    // Shared position-to-slot adder: slot = (head + position) mod DEPTH.
    logic [CW-1:0] pos_sel;
    logic [SW-1:0] sum;
    logic [AW-1:0] slot;

    logic   mem_we, mem_re;
    t_entry mem_wdata, mem_rdata;

    always_comb begin
        lim_wide = CMP'(i_cfg.capacity);
        if (lim_wide > CMP'(DEPTH)) begin
            lim_wide = CMP'(DEPTH);
        end
        if (lim_wide < CMP'(MIN_CAPACITY)) begin
            lim_wide = CMP'(MIN_CAPACITY);
        end
        lim = CW'(lim_wide);
    end

    assign full      = (r_count >= lim);
    assign room_full = (r_count >= lim);
    assign hit       = (mem_rdata.ftype == i_cfg.key_type);
    assign accept    = i_start && !o_busy;

    always_comb begin
        case (r_state)
            S_RD_CHK:  pos_sel = CW'(1);
            S_SCAN_RD: pos_sel = r_idx;
            S_CP_RD:   pos_sel = r_src;
            S_CP_WR:   pos_sel = r_dst;
            S_WRITE:   pos_sel = r_count;
            default:   pos_sel = '0;
        endcase
        sum = SW'(r_head) + SW'(pos_sel);
        if (sum >= SW'(DEPTH)) begin
            sum = sum - SW'(DEPTH);
        end
        slot = AW'(sum);
    end

    assign mem_re    = (r_state == S_RD_HEAD) || (r_state == S_SCAN_RD) ||
                       (r_state == S_CP_RD);
    assign mem_we    = (r_state == S_CP_WR) || (r_state == S_WRITE);
    assign mem_wdata = (r_state == S_WRITE) ? r_in : mem_rdata;

    fqgd_mem #(.DEPTH(DEPTH)) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_re    (mem_re),
        .i_addr  (slot),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_command == CMD_WRITE) begin
                        if (!full) begin
                            n_state = S_WRITE;
                        end else if (!i_blocking) begin
                            n_state = S_SCAN_RD;
                        end
                    end else if (r_count != '0) begin
                        n_state = S_RD_HEAD;
                    end
                end
            end
            S_RD_HEAD:  n_state = S_RD_CHK;
            S_RD_CHK:   n_state = S_IDLE;
            S_SCAN_RD:  n_state = S_SCAN_CHK;
            S_SCAN_CHK: begin
                if ((hit && r_f1) || (r_idx == '0)) begin
                    n_state = S_DROP;
                end else begin
                    n_state = S_SCAN_RD;
                end
            end
            S_DROP:     n_state = r_f2 ? S_CP_RD : S_ROOM;
            S_CP_RD:    n_state = S_CP_WR;
            S_CP_WR:    n_state = (r_src == r_count - CW'(1)) ? S_ROOM : S_CP_RD;
            S_ROOM:     n_state = room_full ? S_IDLE : S_WRITE;
            S_WRITE:    n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    // Datapath and result registers.
    always_comb begin
        n_head    = r_head;
        n_count   = r_count;
        n_cong    = r_cong;
        n_idx     = r_idx;
        n_p1      = r_p1;
        n_p2      = r_p2;
        n_f1      = r_f1;
        n_f2      = r_f2;
        n_src     = r_src;
        n_dst     = r_dst;
        n_in      = r_in;
        n_done    = 1'b0;
        n_ok      = r_ok;
        n_status  = r_status;
        n_out     = r_out;
        n_event   = r_event;
        n_dropped = r_dropped;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_in      = i_item;
                    n_out     = '0;
                    n_ok      = 1'b0;
                    n_status  = ST_OK;
                    n_event   = EV_NONE;
                    n_dropped = '0;
                    if (i_command == CMD_WRITE) begin
                        if (i_cfg.notify && !r_cong &&
                            (CMP'(r_count) > CMP'(i_cfg.warn_level))) begin
                            n_cong  = 1'b1;
                            n_event = EV_ENTER;
                        end
                        if (full) begin
                            if (i_blocking) begin
                                n_status = ST_FULL;
                                n_done   = 1'b1;
                            end else begin
                                n_idx = r_count - CW'(1);
                                n_f1  = 1'b0;
                                n_f2  = 1'b0;
                            end
                        end
                    end else if (r_count == '0) begin
                        n_status = ST_EMPTY;
                        n_done   = 1'b1;
                        if (i_cfg.notify && r_cong) begin
                            n_cong  = 1'b0;
                            n_event = EV_CLEAR;
                        end
                    end
                end
            end
            S_RD_CHK: begin
                n_done = 1'b1;
                if (mem_rdata.fsize == '0) begin
                    n_status = ST_SIZE0;
                end else begin
                    n_out   = mem_rdata;
                    n_ok    = 1'b1;
                    n_head  = slot;
                    n_count = r_count - CW'(1);
                end
            end
            S_SCAN_CHK: begin
                if (hit && !r_f1) begin
                    n_p1 = r_idx;
                    n_f1 = 1'b1;
                end else if (hit) begin
                    n_p2 = r_idx;
                    n_f2 = 1'b1;
                end
                if (r_idx != '0) begin
                    n_idx = r_idx - CW'(1);
                end
            end
            S_DROP: begin
                if (r_f2) begin
                    n_src     = r_p1;
                    n_dst     = r_p2;
                    n_dropped = r_p1 - r_p2;
                end else if (r_f1) begin
                    n_dropped = r_count - r_p1 - CW'(1);
                    n_count   = r_p1 + CW'(1);
                end else begin
                    n_dropped = r_count;
                    n_count   = '0;
                end
            end
            S_CP_WR: begin
                n_src = r_src + CW'(1);
                n_dst = r_dst + CW'(1);
                if (r_src == r_count - CW'(1)) begin
                    n_count = r_count - r_dropped;
                end
            end
            S_ROOM: begin
                if (room_full) begin
                    n_status = ST_NOROOM;
                    n_done   = 1'b1;
                end
            end
            S_WRITE: begin
                n_count  = r_count + CW'(1);
                n_ok     = 1'b1;
                n_status = ST_OK;
                n_done   = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_count <= '0;
            r_cong  <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_count <= n_count;
            r_cong  <= n_cong;
            r_done  <= n_done;
        end
        r_idx     <= n_idx;
        r_p1      <= n_p1;
        r_p2      <= n_p2;
        r_f1      <= n_f1;
        r_f2      <= n_f2;
        r_src     <= n_src;
        r_dst     <= n_dst;
        r_in      <= n_in;
        r_ok      <= n_ok;
        r_status  <= n_status;
        r_out     <= n_out;
        r_event   <= n_event;
        r_dropped <= n_dropped;
    end

    assign o_busy      = (r_state != S_IDLE) || r_done;
    assign o_done      = r_done;
    assign o_ok        = r_ok;
    assign o_status    = r_status;
    assign o_item      = r_out;
    assign o_event     = r_event;
    assign o_occupancy = 7'(r_count);
    assign o_dropped   = 7'(r_dropped);
endmodule
`default_nettype wire

@@ rtl/frame_queue_gop_discard.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Channel     | Handshake                | Payload
// ------------+--------------------------+------------------------------------------
// command     | start, busy              | i_command, i_frame_type, i_frame_ts,
//             |                          | i_frame_size, i_payload_ref, i_blocking
// result      | o_done (one-cycle strobe)| o_ok, o_status, o_out_*, o_congestion_event,
//             |                          | o_occupancy, o_dropped
// config      | i_cfg_we                 | i_cfg_idx, i_cfg_wdata
//
// A write goes on to S_WRITE, a read to S_RD_HEAD and S_RD_CHK; a refused write or empty
// read ends in the accepting cycle; the result beat then follows in a cycle of its own. A
// full non-blocking write first scans back entry by entry for key frames, drops a group
// (moving later descriptors down when a middle group goes), then checks room and writes.
// Reset is synchronous and active low; it empties the queue and loads register defaults.
// The receiver cannot stall: each result beat lasts one cycle and busy stays high in it.
module frame_queue_gop_discard #(
    parameter int DEPTH = 64
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_we,
    input  wire  [1:0]  i_cfg_idx,
    input  wire  [6:0]  i_cfg_wdata,
    input  wire         start,
    output logic        busy,
    input  wire         i_command,
    input  wire  [3:0]  i_frame_type,
    input  wire  [31:0] i_frame_ts,
    input  wire  [23:0] i_frame_size,
    input  wire  [31:0] i_payload_ref,
    input  wire         i_blocking,
    output logic        o_done,
    output logic        o_ok,
    output logic [2:0]  o_status,
    output logic [3:0]  o_out_type,
    output logic [31:0] o_out_ts,
    output logic [23:0] o_out_size,
    output logic [31:0] o_out_payload_ref,
    output logic [1:0]  o_congestion_event,
    output logic [6:0]  o_occupancy,
    output logic [6:0]  o_dropped
);
    import fqgd_pkg::*;

    // Configuration registers. The capacity is clamped to the legal range inside
    // the sequencer, so any value written here is accepted.
    t_cfg   r_cfg;
    t_entry item_in;
    t_entry item_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.capacity   <= CAPACITY_RESET;
            r_cfg.warn_level <= WARN_RESET;
            r_cfg.key_type   <= KEY_RESET;
            r_cfg.notify     <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_CAPACITY: r_cfg.capacity   <= i_cfg_wdata;
                REG_WARN:     r_cfg.warn_level <= i_cfg_wdata;
                REG_KEY:      r_cfg.key_type   <= i_cfg_wdata[3:0];
                REG_NOTIFY:   r_cfg.notify     <= i_cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    assign item_in.ftype = i_frame_type;
    assign item_in.ts    = i_frame_ts;
    assign item_in.fsize = i_frame_size;
    assign item_in.pref  = i_payload_ref;

    // The sequencer owns the descriptor memory, the queue pointers and the
    // congestion flag; all result fields leave it registered.
    fqgd_ctrl #(.DEPTH(DEPTH)) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_start     (start),
        .i_command   (i_command),
        .i_item      (item_in),
        .i_blocking  (i_blocking),
        .o_busy      (busy),
        .o_done      (o_done),
        .o_ok        (o_ok),
        .o_status    (o_status),
        .o_item      (item_out),
        .o_event     (o_congestion_event),
        .o_occupancy (o_occupancy),
        .o_dropped   (o_dropped)
    );

    assign o_out_type        = item_out.ftype;
    assign o_out_ts          = item_out.ts;
    assign o_out_size        = item_out.fsize;
    assign o_out_payload_ref = item_out.pref;
endmodule
`default_nettype wire

@@ rtl/fqgd_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "frame_queue_gop_discard_defines.svh"
module fqgd_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        start,
    input wire        busy,
    input wire        o_done,
    input wire        o_ok,
    input wire [2:0]  o_status,
    input wire [23:0] o_out_size,
    input wire [6:0]  o_occupancy
);
    import fqgd_pkg::*;

    `FQGD_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy)
    `FQGD_ASSERT_NOW(a_done_busy, i_clk, i_rst_n, o_done, busy)
    `FQGD_ASSERT_NOW(a_ok_status, i_clk, i_rst_n, o_done, o_ok == (o_status == ST_OK))
    `FQGD_ASSERT_NOW(a_empty_occ, i_clk, i_rst_n, o_done && o_status == ST_EMPTY, o_occupancy == 7'd0)
    `FQGD_ASSERT_NOW(a_fail_zero, i_clk, i_rst_n, o_done && !o_ok, o_out_size == 24'd0)
endmodule

bind frame_queue_gop_discard fqgd_checker u_fqgd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .o_done      (o_done),
    .o_ok        (o_ok),
    .o_status    (o_status),
    .o_out_size  (o_out_size),
    .o_occupancy (o_occupancy)
);
`default_nettype wire
